FILE: hdl/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared codes and field widths of the fixed-size block free-list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

   localparam int REQ_W    = 2;
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   localparam int MAX_BLOCKS  = 1024;
   localparam int COUNT_RESET = 1024;

   typedef logic [REQ_W-1:0]    req_code_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [INDEX_W-1:0]  index_type;
   typedef logic [COUNT_W-1:0]  count_type;

   localparam req_code_type REQ_INIT  = 2'd0;
   localparam req_code_type REQ_ALLOC = 2'd1;
   localparam req_code_type REQ_FREE  = 2'd2;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_EMPTY     = 2'd1;
   localparam status_type STATUS_OUT_RANGE = 2'd2;

endpackage

FILE: hdl/fbfl_req_if.sv
// ----------------------------------------------------------------------------
// fbfl_req_if
// Request channel: request code and block index with valid/ready.
// ----------------------------------------------------------------------------
interface fbfl_req_if;
   logic                   valid;
   logic                   ready;
   fbfl_pkg::req_code_type req_type;
   fbfl_pkg::index_type    block_index;

   modport source (output valid, output req_type, output block_index, input ready);
   modport sink   (input valid, input req_type, input block_index, output ready);
endinterface

FILE: hdl/fbfl_rsp_if.sv
// ----------------------------------------------------------------------------
// fbfl_rsp_if
// Response channel: status and granted index with valid/ready.
// ----------------------------------------------------------------------------
interface fbfl_rsp_if;
   logic                 valid;
   logic                 ready;
   fbfl_pkg::status_type status;
   fbfl_pkg::index_type  granted_index;

   modport source (output valid, output status, output granted_index, input ready);
   modport sink   (input valid, input status, input granted_index, output ready);
endinterface

FILE: hdl/fbfl_csr_if.sv
// ----------------------------------------------------------------------------
// fbfl_csr_if
// Register write channel: block count write data with valid/ready.
// ----------------------------------------------------------------------------
interface fbfl_csr_if;
   logic                valid;
   logic                ready;
   fbfl_pkg::count_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/fixed_block_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Fixed-size block allocator kept as a linked free list in a link memory.
// ----------------------------------------------------------------------------
// Free, init and alloc-on-empty items skip the read state; an alloc that hands
// out a block goes through it, as the next link comes from the registered link
// memory read port. An init then rewrites the link memory one entry a cycle,
// min(block_count, MAX_BLOCKS) entries, before the next item is taken.
// After reset the same pass runs over min(1024, MAX_BLOCKS) entries with the
// request channel held off; register writes are taken throughout. The count
// register only takes effect at the next init. Double frees are not detected.
module fixed_block_free_list_allocator (
   input  logic       clock,
   input  logic       reset,
   fbfl_req_if.sink   req_port,
   fbfl_rsp_if.source rsp_port,
   fbfl_csr_if.sink   csr_port
);

   localparam int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS;
   localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
   localparam int ADDR_W = $clog2(MAX_BLOCKS);
   localparam int CMP_W  = (LINK_W > fbfl_pkg::COUNT_W) ? LINK_W : fbfl_pkg::COUNT_W;
   localparam int RESET_ACTIVE =
      (fbfl_pkg::COUNT_RESET > MAX_BLOCKS) ? MAX_BLOCKS : fbfl_pkg::COUNT_RESET;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [LINK_W-1:0]         head_ff, head_in;
   logic [LINK_W-1:0]         active_ff, active_in;
   logic [ADDR_W-1:0]         sweep_ff, sweep_in;
   fbfl_pkg::count_type       count_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   fbfl_pkg::status_type      rsp_status_ff, rsp_status_in;
   fbfl_pkg::index_type       rsp_granted_ff, rsp_granted_in;

   logic [LINK_W-1:0]         mem [MAX_BLOCKS];
   logic [LINK_W-1:0]         rd_data_ff;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic [LINK_W-1:0]         wr_data;

   logic                      req_fire;
   logic                      slot_free;
   logic [CMP_W-1:0]          idx_ext;
   logic [CMP_W-1:0]          count_ext;
   logic [CMP_W-1:0]          count_sat;
   logic [CMP_W-1:0]          head_ext;
   logic [LINK_W-1:0]         sweep_next;
   logic                      idx_ok;

   assign slot_free        = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready   = (state_ff == ST_IDLE) && slot_free;
   assign req_fire         = req_port.valid && req_port.ready;
   assign csr_port.ready   = 1'b1;

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.status        = rsp_status_ff;
   assign rsp_port.granted_index = rsp_granted_ff;

   assign idx_ext    = CMP_W'(req_port.block_index);
   assign count_ext  = CMP_W'(count_ff);
   assign count_sat  = (count_ext > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : count_ext;
   assign head_ext   = CMP_W'(head_ff);
   assign sweep_next = LINK_W'(sweep_ff) + LINK_W'(1);
   assign idx_ok     = (idx_ext < CMP_W'(active_ff)) && (idx_ext < CMP_W'(MAX_BLOCKS));

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      active_in      = active_ff;
      sweep_in       = sweep_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_port.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      wr_en          = 1'b0;
      wr_addr        = sweep_ff;
      wr_data        = (sweep_next < active_ff) ? sweep_next : NULL_LINK;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_status_in  = fbfl_pkg::STATUS_OK;
               rsp_granted_in = '0;
               case (req_port.req_type)
                  fbfl_pkg::REQ_INIT: begin
                     rsp_valid_in = 1'b1;
                     active_in    = LINK_W'(count_sat);
                     sweep_in     = '0;
                     if (count_sat == '0) begin
                        head_in = NULL_LINK;
                     end else begin
                        head_in  = '0;
                        state_in = ST_SWEEP;
                     end
                  end
                  fbfl_pkg::REQ_ALLOC: begin
                     if (head_ff == NULL_LINK) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = fbfl_pkg::STATUS_EMPTY;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  fbfl_pkg::REQ_FREE: begin
                     rsp_valid_in = 1'b1;
                     if (idx_ok) begin
                        wr_en   = 1'b1;
                        wr_addr = idx_ext[ADDR_W-1:0];
                        wr_data = head_ff;
                        head_in = LINK_W'(idx_ext);
                     end else begin
                        rsp_status_in = fbfl_pkg::STATUS_OUT_RANGE;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = fbfl_pkg::STATUS_OK;
            rsp_granted_in = head_ext[fbfl_pkg::INDEX_W-1:0];
            head_in        = rd_data_ff;
            state_in       = ST_IDLE;
         end
         ST_SWEEP: begin
            wr_en    = 1'b1;
            sweep_in = sweep_next[ADDR_W-1:0];
            if (sweep_next == active_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         head_ff      <= '0;
         active_ff    <= LINK_W'(RESET_ACTIVE);
         sweep_ff     <= '0;
         count_ff     <= fbfl_pkg::count_type'(fbfl_pkg::COUNT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         active_ff    <= active_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_port.valid) begin
            count_ff <= csr_port.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
   end

   // link memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[head_ff[ADDR_W-1:0]];
   end

endmodule
